FILE: design/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg: shared types, constants and helpers for the Boolean matrix power
// Sizes of the row store, configuration codes, sequencer states, the size
// clamp used by the top level and the row mask helper used by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bmp_pkg;

  // Matrix geometry
  localparam int unsigned MaxSize = 32;
  localparam int unsigned RowW    = 32;
  localparam int unsigned IdxW    = $clog2(MaxSize);
  localparam int unsigned CntW    = $clog2(MaxSize + 1);

  // Configuration registers
  localparam int unsigned SizeW    = 6;
  localparam int unsigned PowW     = 10;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CfgMatrixSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPowerExp   = 1'b1;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(32);
  localparam logic [PowW-1:0]  PowReset  = PowW'(1);

  // Sequencer states
  typedef enum logic [1:0] {
    StLoad,
    StStart,
    StIter,
    StEmit
  } seq_state_e;

  // Write request into the base row store
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
  } base_wr_t;

  // Clamp the programmed size into 1..MaxSize
  function automatic logic [CntW-1:0] eff_size(logic [SizeW-1:0] size);
    logic [CntW-1:0] n;
    if (size == '0) begin
      n = CntW'(1);
    end else if (size > SizeW'(MaxSize)) begin
      n = CntW'(MaxSize);
    end else begin
      n = CntW'(size);
    end
    return n;
  endfunction

  // Low n bits set
  function automatic logic [RowW-1:0] row_mask(logic [CntW-1:0] n);
    logic [RowW:0] t;
    t = (RowW+1)'(1) << n;
    return RowW'(t - (RowW+1)'(1));
  endfunction

endpackage

`default_nettype wire

FILE: design/boolean_matrix_power_top.sv
// ----------------------------------------------------------------------------
// boolean_matrix_power_top: Boolean power of a loaded relation matrix
// Loads n rows, then emits the n rows of the m-th Boolean power, built by
// repeated composition with the base matrix in one shared unit.
//
//   channel | handshake                  | payload
//   --------+----------------------------+----------------------------------
//   in      | in_valid_i / in_stall_o    | in_row_i, in_last_i
//   out     | out_valid_o / out_stall_i  | out_index_o, out_row_o, out_last_o
//   cfg     | cfg_we_i                   | cfg_index_i, cfg_wdata_i
//
// Rows load one per cycle. After the last row each result row is seeded from
// its base row (a unit row for m = 0), composed max(m-1, 0) times with the
// base matrix in the composition unit, one step per cycle, and held in the
// working row register until taken. Input is stalled from the last row until
// the final result row is taken. Reset sets n = 32, m = 1 and clears the load
// count; the base rows hold no reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module boolean_matrix_power_top (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire  [bmp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire  [bmp_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [31:0]                     in_row_i,
  input  wire                             in_last_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [4:0]                      out_index_o,
  output logic [31:0]                     out_row_o,
  output logic                            out_last_o
);

  logic [bmp_pkg::SizeW-1:0] size_q;
  logic [bmp_pkg::PowW-1:0]  pow_q;
  logic [bmp_pkg::CntW-1:0]  n_eff;

  bmp_pkg::base_wr_t         base_wr;
  logic [bmp_pkg::RowW-1:0]  base_wdata;
  logic [bmp_pkg::IdxW-1:0]  base_raddr;
  logic [bmp_pkg::RowW-1:0]  base_rdata;
  logic [bmp_pkg::RowW-1:0]  comp_in;
  logic [bmp_pkg::RowW-1:0]  comp_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= bmp_pkg::SizeReset;
      pow_q  <= bmp_pkg::PowReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bmp_pkg::CfgMatrixSize: size_q <= cfg_wdata_i[bmp_pkg::SizeW-1:0];
        bmp_pkg::CfgPowerExp:   pow_q  <= cfg_wdata_i[bmp_pkg::PowW-1:0];
        default: begin
          size_q <= size_q;
        end
      endcase
    end
  end

  // Clamp the size in force
  assign n_eff = bmp_pkg::eff_size(size_q);

  bmp_rows u_rows (
    .clk_i      (clk_i),
    .wr_i       (base_wr),
    .wdata_i    (base_wdata),
    .raddr_i    (base_raddr),
    .rdata_o    (base_rdata),
    .comp_in_i  (comp_in),
    .comp_out_o (comp_out)
  );

  bmp_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .n_i          (n_eff),
    .m_i          (pow_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_row_i     (in_row_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_index_o  (out_index_o),
    .out_row_o    (out_row_o),
    .out_last_o   (out_last_o),
    .base_wr_o    (base_wr),
    .base_wdata_o (base_wdata),
    .base_raddr_o (base_raddr),
    .base_rdata_i (base_rdata),
    .comp_in_o    (comp_in),
    .comp_out_i   (comp_out)
  );

endmodule

`default_nettype wire

FILE: design/bmp_rows.sv
// ----------------------------------------------------------------------------
// bmp_rows: base row store and shared composition unit
// Holds the loaded base rows and forms, for one power row, the OR of every
// base row k whose bit k is set in that power row.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_rows (
  input  wire                        clk_i,
  input  bmp_pkg::base_wr_t          wr_i,
  input  wire  [bmp_pkg::RowW-1:0]   wdata_i,
  input  wire  [bmp_pkg::IdxW-1:0]   raddr_i,
  output logic [bmp_pkg::RowW-1:0]   rdata_o,
  input  wire  [bmp_pkg::RowW-1:0]   comp_in_i,
  output logic [bmp_pkg::RowW-1:0]   comp_out_o
);

  logic [bmp_pkg::RowW-1:0] base_q [bmp_pkg::MaxSize];

  // Store one loaded row
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      base_q[wr_i.addr] <= wdata_i;
    end
  end

  // Read one base row to seed a power row
  assign rdata_o = base_q[raddr_i];

  // Compose: AND each selector bit with its base row, OR over all rows
  always_comb begin
    comp_out_o = '0;
    for (int k = 0; k < bmp_pkg::MaxSize; k++) begin
      comp_out_o = comp_out_o | (base_q[k] & {bmp_pkg::RowW{comp_in_i[k]}});
    end
  end

endmodule

`default_nettype wire

FILE: design/bmp_seq.sv
// ----------------------------------------------------------------------------
// bmp_seq: load and power sequencer
// Takes rows into the base store, then for each result row seeds it from the
// base row, or for m = 0 a unit row, composes it max(m-1, 0) times, emits it.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_seq (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [bmp_pkg::CntW-1:0]     n_i,
  input  wire  [bmp_pkg::PowW-1:0]     m_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [bmp_pkg::RowW-1:0]     in_row_i,
  input  wire                          in_last_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [bmp_pkg::IdxW-1:0]     out_index_o,
  output logic [bmp_pkg::RowW-1:0]     out_row_o,
  output logic                         out_last_o,
  output bmp_pkg::base_wr_t            base_wr_o,
  output logic [bmp_pkg::RowW-1:0]     base_wdata_o,
  output logic [bmp_pkg::IdxW-1:0]     base_raddr_o,
  input  wire  [bmp_pkg::RowW-1:0]     base_rdata_i,
  output logic [bmp_pkg::RowW-1:0]     comp_in_o,
  input  wire  [bmp_pkg::RowW-1:0]     comp_out_i
);

  bmp_pkg::seq_state_e state_q, state_d;

  logic [bmp_pkg::IdxW-1:0] idx_q;
  logic [bmp_pkg::CntW-1:0] rows_q;
  logic [bmp_pkg::PowW-1:0] rem_q;
  logic [bmp_pkg::RowW-1:0] row_q;

  logic [bmp_pkg::RowW-1:0] mask;
  logic                     in_acc;
  logic                     out_acc;
  logic                     row_final;

  assign mask      = bmp_pkg::row_mask(n_i);
  assign in_acc    = in_valid_i & ~in_stall_o;
  assign out_acc   = out_valid_o & ~out_stall_i;
  assign row_final = (idx_q == bmp_pkg::IdxW'(n_i - bmp_pkg::CntW'(1)));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bmp_pkg::StLoad: begin
        if (in_acc && in_last_i) state_d = bmp_pkg::StStart;
      end
      bmp_pkg::StStart: begin
        if (m_i <= bmp_pkg::PowW'(1)) state_d = bmp_pkg::StEmit;
        else                          state_d = bmp_pkg::StIter;
      end
      bmp_pkg::StIter: begin
        if (rem_q == bmp_pkg::PowW'(1)) state_d = bmp_pkg::StEmit;
      end
      bmp_pkg::StEmit: begin
        if (out_acc) state_d = row_final ? bmp_pkg::StLoad : bmp_pkg::StStart;
      end
      default: state_d = bmp_pkg::StLoad;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o     = (state_q != bmp_pkg::StLoad);
    out_valid_o    = (state_q == bmp_pkg::StEmit);
    out_index_o    = idx_q;
    out_row_o      = row_q & mask;
    out_last_o     = row_final;
    base_wr_o.we   = in_acc && (rows_q < n_i);
    base_wr_o.addr = rows_q[bmp_pkg::IdxW-1:0];
    base_wdata_o   = in_row_i & mask;
    base_raddr_o   = idx_q;
    comp_in_o      = row_q & mask;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmp_pkg::StLoad;
      idx_q   <= '0;
      rows_q  <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        bmp_pkg::StLoad: begin
          if (in_acc) begin
            if (in_last_i) begin
              rows_q <= '0;
              idx_q  <= '0;
            end else if (rows_q < n_i) begin
              rows_q <= rows_q + bmp_pkg::CntW'(1);
            end
          end
        end
        bmp_pkg::StStart: begin
          rem_q <= m_i - bmp_pkg::PowW'(1);
        end
        bmp_pkg::StIter: begin
          rem_q <= rem_q - bmp_pkg::PowW'(1);
        end
        bmp_pkg::StEmit: begin
          if (out_acc && !row_final) idx_q <= idx_q + bmp_pkg::IdxW'(1);
        end
        default: begin
          rows_q <= '0;
        end
      endcase
    end
  end

  // Working power row: seed, then compose in place
  always_ff @(posedge clk_i) begin
    case (state_q)
      bmp_pkg::StStart: begin
        if (m_i == '0) row_q <= bmp_pkg::RowW'(1) << idx_q;
        else           row_q <= base_rdata_i;
      end
      bmp_pkg::StIter: begin
        row_q <= comp_out_i;
      end
      default: begin
        row_q <= row_q;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // A final load row starts the run at row zero
  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_last_i) |=> (state_q == bmp_pkg::StStart && idx_q == '0))
    else $error("run did not start at row zero");

  // A taken non-final result advances the row number by one
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !out_last_o) |=> (idx_q == $past(idx_q) + bmp_pkg::IdxW'(1)))
    else $error("row number did not advance by one");

  // The final result returns to loading with an empty store count
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last_o) |=> (state_q == bmp_pkg::StLoad && rows_q == '0))
    else $error("run did not end cleanly");

  // The composition count never runs out while iterating
  a_rem_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmp_pkg::StIter) |-> (rem_q != '0))
    else $error("composition count underflow");
`endif

endmodule

`default_nettype wire
